FILE: hdl/crate_pkg.sv
package crate_pkg;

    localparam int SLOT_COUNT    = 32;
    localparam int CHANNEL_COUNT = 64;

    // Result queue between the decoder and the output port.
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int RES_CW     = $clog2(MAX_RES + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_WORD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_WORD      = 2'd3;

    localparam logic [31:0] RST_BEGIN_MASK    = 32'hFFFF_FF00;
    localparam logic [31:0] RST_BEGIN_PATTERN = 32'h0000_0000;
    localparam logic [31:0] RST_ALIGN_WORD    = 32'h0000_0000;
    localparam logic [31:0] RST_END_WORD      = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [2:0] ST_COUNT_DONE = 3'd0;
    localparam logic [2:0] ST_END_MARKER = 3'd1;
    localparam logic [2:0] ST_BUF_ENDED  = 3'd2;
    localparam logic [2:0] ST_SLOT_OVER  = 3'd3;
    localparam logic [2:0] ST_BAD_HEADER = 3'd4;
    localparam logic [2:0] ST_SHORT      = 3'd5;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_BOARD,
        PH_ALIGNED,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [5:0]  channel;
        logic [13:0] adc_value;
        logic [63:0] hit_mask;
        logic [6:0]  sample_count;
        logic [7:0]  board_total;
        logic [2:0]  status;
        logic        final_res;
    } t_out;

    function automatic t_out mk_sample(logic [4:0] slot, logic [5:0] ch, logic [13:0] val);
        t_out r;
        r           = '0;
        r.kind      = KIND_SAMPLE;
        r.slot      = slot;
        r.channel   = ch;
        r.adc_value = val;
        return r;
    endfunction

    function automatic t_out mk_summary(logic [4:0] slot, logic [63:0] mask, logic [6:0] cnt);
        t_out r;
        r              = '0;
        r.kind         = KIND_SUMMARY;
        r.slot         = slot;
        r.hit_mask     = mask;
        r.sample_count = cnt;
        return r;
    endfunction

    function automatic t_out mk_end(logic [7:0] total, logic [2:0] status);
        t_out r;
        r             = '0;
        r.kind        = KIND_END;
        r.board_total = total;
        r.status      = status;
        return r;
    endfunction

endpackage

FILE: hdl/crate_adc_readout_parser.sv
// Results are written into the result queue when their word is accepted. One word per
// cycle is decoded unless the input stalls; results leave the eight-entry queue one per
// cycle unless the output stalls, and the input stalls while fewer than three entries
// are free. A word causes at most three results (a sample, a board summary, a buffer end).
// Reset is synchronous and active low: the decoder returns to expecting a crate header,
// its counters and the result queue are cleared, and the registers take their reset values.
module crate_adc_readout_parser #(
    parameter int P_SLOT_COUNT    = crate_pkg::SLOT_COUNT,
    parameter int P_CHANNEL_COUNT = crate_pkg::CHANNEL_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crate_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  crate_pkg::t_in                 i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output crate_pkg::t_out                o_out
);
    import crate_pkg::*;

    logic [31:0] r_begin_mask, r_begin_pattern, r_align_word, r_end_word;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_boards_left, n_boards_left;
    logic [6:0]  r_bwl, n_bwl;
    logic [4:0]  r_slot, n_slot;
    logic [63:0] r_mask, n_mask;
    logic [6:0]  r_cnt, n_cnt;
    logic [7:0]  r_boards_done, n_boards_done;

    t_out              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;

    t_out              res [MAX_RES];
    logic [RES_CW-1:0] res_cnt;

    logic        in_acc, pop, close_chk;
    logic [4:0]  w_slot;
    logic [5:0]  w_ch;
    logic [6:0]  w_len;

    assign in_acc = i_in_valid && !o_in_stall;
    assign pop    = o_out_valid && !i_out_stall;
    assign w_slot = i_in.word[31:27];
    assign w_ch   = i_in.word[22:17];
    assign w_len  = i_in.word[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_mask    <= RST_BEGIN_MASK;
            r_begin_pattern <= RST_BEGIN_PATTERN;
            r_align_word    <= RST_ALIGN_WORD;
            r_end_word      <= RST_END_WORD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BEGIN_MASK:    r_begin_mask    <= i_cfg_data;
                CFG_BEGIN_PATTERN: r_begin_pattern <= i_cfg_data;
                CFG_ALIGN_WORD:    r_align_word    <= i_cfg_data;
                CFG_END_WORD:      r_end_word      <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR;
            r_boards_left <= '0;
            r_bwl         <= '0;
            r_slot        <= '0;
            r_mask        <= '0;
            r_cnt         <= '0;
            r_boards_done <= '0;
        end else begin
            r_phase       <= n_phase;
            r_boards_left <= n_boards_left;
            r_bwl         <= n_bwl;
            r_slot        <= n_slot;
            r_mask        <= n_mask;
            r_cnt         <= n_cnt;
            r_boards_done <= n_boards_done;
        end
    end

    // Decode one word: next state and the list of results it causes.
    always_comb begin
        n_phase       = r_phase;
        n_boards_left = r_boards_left;
        n_bwl         = r_bwl;
        n_slot        = r_slot;
        n_mask        = r_mask;
        n_cnt         = r_cnt;
        n_boards_done = r_boards_done;
        close_chk     = 1'b0;
        res_cnt       = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end

        if (in_acc) begin
            case (r_phase)
                PH_HDR: begin
                    n_boards_done = '0;
                    if (i_in.last) begin
                        res[res_cnt] = mk_end(8'd0, ST_SHORT);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = PH_HDR;
                    end else if ((i_in.word & r_begin_mask) != r_begin_pattern) begin
                        res[res_cnt] = mk_end(8'd0, ST_BAD_HEADER);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = PH_DONE;
                    end else begin
                        n_boards_left = i_in.word[7:0];
                        if (i_in.word[7:0] == 8'd0) begin
                            res[res_cnt] = mk_end(8'd0, ST_COUNT_DONE);
                            res_cnt      = res_cnt + 1'b1;
                            n_phase      = PH_DONE;
                        end else begin
                            n_phase = PH_BOARD;
                        end
                    end
                end
                PH_BOARD, PH_ALIGNED: begin
                    if (r_phase == PH_BOARD && i_in.word == r_align_word) begin
                        if (i_in.last) begin
                            res[res_cnt] = mk_end(r_boards_done, ST_BUF_ENDED);
                            res_cnt      = res_cnt + 1'b1;
                            n_phase      = PH_HDR;
                        end else begin
                            n_phase = PH_ALIGNED;
                        end
                    end else if (i_in.word == r_end_word) begin
                        res[res_cnt] = mk_end(r_boards_done, ST_END_MARKER);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = i_in.last ? PH_HDR : PH_DONE;
                    end else if ({1'b0, w_slot} >= 6'(P_SLOT_COUNT)) begin
                        res[res_cnt] = mk_end(r_boards_done, ST_SLOT_OVER);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = i_in.last ? PH_HDR : PH_DONE;
                    end else begin
                        n_slot    = w_slot;
                        n_mask    = '0;
                        n_cnt     = '0;
                        n_bwl     = (w_len != 7'd0) ? w_len - 7'd1 : 7'd0;
                        close_chk = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (w_slot == r_slot && {1'b0, w_ch} < 7'(P_CHANNEL_COUNT)) begin
                        res[res_cnt] = mk_sample(r_slot, w_ch, i_in.word[13:0]);
                        res_cnt      = res_cnt + 1'b1;
                        n_mask       = r_mask | (64'd1 << w_ch);
                        n_cnt        = r_cnt + 7'd1;
                    end
                    n_bwl     = r_bwl - 7'd1;
                    close_chk = 1'b1;
                end
                PH_DONE: begin
                    if (i_in.last) begin
                        n_phase = PH_HDR;
                    end
                end
                default: n_phase = PH_HDR;
            endcase

            // A board closes when its word count runs out or the buffer ends inside it.
            if (close_chk) begin
                if (n_bwl != 7'd0 && !i_in.last) begin
                    n_phase = PH_DATA;
                end else begin
                    res[res_cnt]  = mk_summary(n_slot, n_mask, n_cnt);
                    res_cnt       = res_cnt + 1'b1;
                    n_boards_done = r_boards_done + 8'd1;
                    n_boards_left = r_boards_left - 8'd1;
                    if (n_boards_left == 8'd0) begin
                        res[res_cnt] = mk_end(n_boards_done, ST_COUNT_DONE);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = i_in.last ? PH_HDR : PH_DONE;
                    end else if (i_in.last) begin
                        res[res_cnt] = mk_end(n_boards_done, ST_BUF_ENDED);
                        res_cnt      = res_cnt + 1'b1;
                        n_phase      = PH_HDR;
                    end else begin
                        n_phase = PH_BOARD;
                    end
                end
            end

            if (res_cnt != '0) begin
                res[res_cnt - 1'b1].final_res = 1'b1;
            end
        end
    end

    // Result queue: up to three pushes and one pop per cycle.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_CW'(i) < res_cnt) begin
                r_fifo[r_wr_ptr + FIFO_AW'(i)] <= res[i];
            end
        end
    end

    assign n_count = r_count + FIFO_CW'(res_cnt) - FIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(res_cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= n_count;
        end
    end

    assign o_in_stall  = r_count > FIFO_CW'(FIFO_DEPTH - MAX_RES);
    assign o_out_valid = r_count != '0;
    assign o_out       = r_fifo[r_rd_ptr];

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_fifo_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |-> r_count == $past(n_count))
        else $error("result queue count lost track");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> res_cnt == '0)
        else $error("result produced while waiting for the last word");

    a_short_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_HDR && i_in.last)
            |-> (res_cnt == RES_CW'(1) && res[0].status == ST_SHORT) ##1 r_phase == PH_HDR)
        else $error("short buffer not reported as a single buffer end");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import crate_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_BEGIN_MASK;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;

    // Register copies and decoder state of the predictor.
    logic [31:0] cfg_begin_mask = RST_BEGIN_MASK;
    logic [31:0] cfg_begin_pattern = RST_BEGIN_PATTERN;
    logic [31:0] cfg_align_word = RST_ALIGN_WORD;
    logic [31:0] cfg_end_word = RST_END_WORD;
    t_phase dec_phase = PH_HDR;
    logic [7:0] boards_left = '0;
    logic [6:0] words_left = '0;
    logic [4:0] cur_slot = '0;
    logic [63:0] mask_acc = '0;
    logic [6:0] count_acc = '0;
    logic [7:0] boards_done = '0;

    t_out step_results[$];
    t_out expected_results[$];
    logic [31:0] buffer_words[$];

    int errors = 0;
    int words_sent = 0;
    int burst_left = 0;
    int idle_count = 0;
    int stall_cycle = 0;
    t_stall_mode stall_mode = STALL_NONE;

    crate_adc_readout_parser uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    always #2 clk = ~clk;

    function automatic void emit_buffer_end(logic [2:0] status, logic last);
        t_out r;
        r = '0;
        r.kind = KIND_END;
        r.board_total = boards_done;
        r.status = status;
        step_results.push_back(r);
        dec_phase = last ? PH_HDR : PH_DONE;
    endfunction

    function automatic void close_board(logic last);
        t_out r;
        if (words_left != 7'd0 && !last) begin
            dec_phase = PH_DATA;
        end else begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.slot = cur_slot;
            r.hit_mask = mask_acc;
            r.sample_count = count_acc;
            step_results.push_back(r);
            boards_done = boards_done + 8'd1;
            boards_left = boards_left - 8'd1;
            if (boards_left == 8'd0) begin
                emit_buffer_end(ST_COUNT_DONE, last);
            end else if (last) begin
                emit_buffer_end(ST_BUF_ENDED, last);
            end else begin
                dec_phase = PH_BOARD;
            end
        end
    endfunction

    function automatic void decode_word(logic [31:0] w, logic last);
        logic [4:0] w_slot;
        logic [5:0] w_chan;
        t_out r;
        w_slot = w[31:27];
        w_chan = w[22:17];
        step_results.delete();
        case (dec_phase)
            PH_HDR: begin
                boards_done = '0;
                if (last) begin
                    emit_buffer_end(ST_SHORT, last);
                end else if ((w & cfg_begin_mask) != cfg_begin_pattern) begin
                    emit_buffer_end(ST_BAD_HEADER, last);
                end else begin
                    boards_left = w[7:0];
                    if (boards_left == 8'd0) begin
                        emit_buffer_end(ST_COUNT_DONE, last);
                    end else begin
                        dec_phase = PH_BOARD;
                    end
                end
            end
            PH_BOARD, PH_ALIGNED: begin
                // Only one alignment word is skipped; a second one is taken as a header.
                if (dec_phase == PH_BOARD && w == cfg_align_word) begin
                    if (last) begin
                        emit_buffer_end(ST_BUF_ENDED, last);
                    end else begin
                        dec_phase = PH_ALIGNED;
                    end
                end else if (w == cfg_end_word) begin
                    emit_buffer_end(ST_END_MARKER, last);
                end else if (int'(w_slot) >= SLOT_COUNT) begin
                    emit_buffer_end(ST_SLOT_OVER, last);
                end else begin
                    cur_slot = w_slot;
                    mask_acc = '0;
                    count_acc = '0;
                    words_left = (w[6:0] >= 7'd1) ? w[6:0] - 7'd1 : 7'd0;
                    close_board(last);
                end
            end
            PH_DATA: begin
                if (w_slot == cur_slot && int'(w_chan) < CHANNEL_COUNT) begin
                    r = '0;
                    r.kind = KIND_SAMPLE;
                    r.slot = cur_slot;
                    r.channel = w_chan;
                    r.adc_value = w[13:0];
                    step_results.push_back(r);
                    mask_acc = mask_acc | (64'd1 << w_chan);
                    count_acc = count_acc + 7'd1;
                end
                words_left = words_left - 7'd1;
                close_board(last);
            end
            default: begin
                if (last) begin
                    dec_phase = PH_HDR;
                end
            end
        endcase
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.final_res = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i]) begin
            expected_results.push_back(step_results[i]);
        end
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_word(logic [31:0] w, logic last);
        pace_sender();
        in_valid <= 1'b1;
        in_item <= {w, last};
        do @(posedge clk); while (in_stall);
        decode_word(w, last);
        words_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_BEGIN_MASK:    cfg_begin_mask = value;
            CFG_BEGIN_PATTERN: cfg_begin_pattern = value;
            CFG_ALIGN_WORD:    cfg_align_word = value;
            default:           cfg_end_word = value;
        endcase
    endtask

    task automatic write_registers(logic [31:0] mask, logic [31:0] pattern,
                                   logic [31:0] align, logic [31:0] end_marker);
        write_reg(CFG_BEGIN_MASK, mask);
        write_reg(CFG_BEGIN_PATTERN, pattern);
        write_reg(CFG_ALIGN_WORD, align);
        write_reg(CFG_END_WORD, end_marker);
        cfg_we <= 1'b0;
    endtask

    // Builds one crate buffer: mostly well formed, sometimes noise, cut short or padded.
    task automatic make_buffer();
        logic [31:0] hdr;
        logic [31:0] w;
        logic [7:0] want;
        logic [4:0] board_slot;
        int pick, boards, sections, len, keep;
        buffer_words.delete();
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6)) buffer_words.push_back($urandom);
        end else begin
            want = 8'($urandom_range(0, 4));
            hdr = ($urandom & ~cfg_begin_mask) | (cfg_begin_pattern & cfg_begin_mask);
            hdr[7:0] = (want & ~cfg_begin_mask[7:0])
                     | (cfg_begin_pattern[7:0] & cfg_begin_mask[7:0]);
            if (pick == 1) begin
                hdr = $urandom;
            end
            buffer_words.push_back(hdr);
            boards = hdr[7:0];
            sections = (boards > 5) ? 5 : boards;
            for (int s = 0; s < sections; s++) begin
                if ($urandom_range(0, 2) == 0) buffer_words.push_back(cfg_align_word);
                if ($urandom_range(0, 11) == 0) buffer_words.push_back(cfg_align_word);
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
                w = $urandom;
                board_slot = w[31:27];
                w[6:0] = 7'(len);
                buffer_words.push_back(w);
                for (int i = 1; i < len; i++) begin
                    w = $urandom;
                    if ($urandom_range(0, 5) != 0) w[31:27] = board_slot;
                    buffer_words.push_back(w);
                end
            end
            if ($urandom_range(0, 7) == 0) buffer_words.push_back(cfg_end_word);
            case ($urandom_range(0, 3))
                0: begin
                    keep = $urandom_range(1, buffer_words.size());
                    while (buffer_words.size() > keep) void'(buffer_words.pop_back());
                end
                1: repeat ($urandom_range(1, 3)) buffer_words.push_back($urandom);
                default: ;
            endcase
        end
    endtask

    task automatic run_buffers(int word_budget);
        int stop_at;
        stop_at = words_sent + word_budget;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) wait_results();
            make_buffer();
            for (int i = 0; i < buffer_words.size(); i++) begin
                send_word(buffer_words[i], i == buffer_words.size() - 1);
            end
        end
    endtask

    task automatic test_directed_cases();
        // Header that is also the last word.
        send_word(32'hFFFF_FFFF, 1'b1);
        // Bad header, then words ignored up to the last one.
        send_word(32'h1234_5600, 1'b0);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'hDEAD_BEEF, 1'b1);
        // Zero boards.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h5555_5555, 1'b1);
        // Three boards: alignment, an all-ones data word, a skipped slot, a short board,
        // and the last board closing on the last word.
        send_word(32'h0000_0003, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hF800_0004, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hF800_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0800_0000, 1'b0);
        send_word(32'h1000_0002, 1'b0);
        send_word(32'h1000_0123, 1'b1);
        // End marker where a board header is expected.
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h1800_0001, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hABCD_EF01, 1'b1);
        // Buffer ends inside a board.
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h2000_0010, 1'b0);
        send_word(32'h207E_ABCD, 1'b1);
        // Alignment word as the last word.
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        // Board header as the last word with boards still missing.
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h2800_0001, 1'b1);
    endtask

    task automatic test_reset_registers();
        run_buffers(90);
    endtask

    task automatic test_open_header();
        wait_results();
        write_registers(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        run_buffers(90);
    endtask

    task automatic test_exact_header();
        wait_results();
        write_registers(32'hFFFF_FFFF, 32'hA5A5_A503, 32'h1234_5678, 32'h8765_4321);
        run_buffers(90);
    endtask

    task automatic test_random_registers();
        logic [31:0] mask;
        mask = $urandom & 32'hFFFF_FF00;
        wait_results();
        write_registers(mask, $urandom & mask, $urandom, $urandom);
        run_buffers(90);
    endtask

    task automatic test_restored_registers();
        wait_results();
        write_registers(RST_BEGIN_MASK, RST_BEGIN_PATTERN, RST_ALIGN_WORD, RST_END_WORD);
        run_buffers(70);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_reset_registers();
        test_open_header();
        test_exact_header();
        test_random_registers();
        test_restored_registers();
        wait_results();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("crate_adc_readout_parser: match");
        end else begin
            $display("crate_adc_readout_parser: mismatch");
        end
        $finish;
    end

    // The receiver switches at random between no, light, heavy and periodic stalls.
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= stall_cycle[2];
        endcase
    end

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, out_item);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_item.kind !== want.kind)
                    report_field("kind", 64'(want.kind), 64'(out_item.kind));
                if (out_item.slot !== want.slot)
                    report_field("slot", 64'(want.slot), 64'(out_item.slot));
                if (out_item.channel !== want.channel)
                    report_field("channel", 64'(want.channel), 64'(out_item.channel));
                if (out_item.adc_value !== want.adc_value)
                    report_field("adc_value", 64'(want.adc_value), 64'(out_item.adc_value));
                if (out_item.hit_mask !== want.hit_mask)
                    report_field("hit_mask", want.hit_mask, out_item.hit_mask);
                if (out_item.sample_count !== want.sample_count)
                    report_field("sample_count", 64'(want.sample_count),
                                 64'(out_item.sample_count));
                if (out_item.board_total !== want.board_total)
                    report_field("board_total", 64'(want.board_total),
                                 64'(out_item.board_total));
                if (out_item.status !== want.status)
                    report_field("status", 64'(want.status), 64'(out_item.status));
                if (out_item.final_res !== want.final_res)
                    report_field("final_res", 64'(want.final_res), 64'(out_item.final_res));
            end
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("crate_adc_readout_parser: mismatch");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

endmodule

FILE: crate_adc_readout_parser.f
hdl/crate_pkg.sv
hdl/crate_adc_readout_parser.sv
tb/sv/testbench.sv
